[rtl/core/text_console_writer_top_assert.svh]
// Assertion macros shared by the text console writer RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/tcw_pkg.sv]
// Package for the text console writer: field widths, character codes and
// the command type passed from the front end to the execution back end.
// No dependencies.
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int unsigned COLUMNS_DEFAULT = 80;
  localparam int unsigned ROWS_DEFAULT    = 25;

  localparam int unsigned ACTION_W   = 1;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned INDEX_W    = 11;
  localparam int unsigned COLOR_W    = 8;
  localparam int unsigned CELL_W     = 16;
  localparam int unsigned COL_PORT_W = 7;
  localparam int unsigned ROW_PORT_W = 5;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [ACTION_W-1:0] ACTION_READ  = 1'b1;
  localparam logic [CHAR_W-1:0]   BLANK_CHAR   = 8'h20;
  localparam logic [CHAR_W-1:0]   NEWLINE_CHAR = 8'h0A;
  localparam logic [COLOR_W-1:0]  RESET_COLOR  = 8'h07;

  typedef enum logic [1:0] {
    OP_PUT,
    OP_NEWLINE,
    OP_READ
  } tcw_op_e;

  typedef struct packed {
    tcw_op_e              op;
    logic [CHAR_W-1:0]    glyph;
    logic [INDEX_W-1:0]   index;
    logic                 in_range;
  } tcw_cmd_t;

endpackage

[rtl/core/tcw_front.sv]
// Front end of the text console writer: accepts input transactions and
// classifies them into commands held in one register stage. Uses tcw_pkg.
`timescale 1ns / 1ps

module tcw_front #(
  parameter int unsigned COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
  parameter int unsigned ROWS    = tcw_pkg::ROWS_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           clear_busy_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [tcw_pkg::ACTION_W-1:0]   action_i,
  input  logic [tcw_pkg::CHAR_W-1:0]     char_code_i,
  input  logic [tcw_pkg::INDEX_W-1:0]    cell_index_i,
  output logic                           push_valid_o,
  input  logic                           push_ready_i,
  output tcw_pkg::tcw_cmd_t              push_cmd_o
);

  import tcw_pkg::*;

  localparam int unsigned CellCount = COLUMNS * ROWS;

  logic     hold_q, hold_d;
  tcw_cmd_t cmd_q, cmd_d;
  logic     accept;

  assign in_ready_o   = !clear_busy_i && (!hold_q || push_ready_i);
  assign accept       = in_valid_i && in_ready_o;
  assign push_valid_o = hold_q;
  assign push_cmd_o   = cmd_q;

  always_comb begin
    cmd_d.glyph    = char_code_i;
    cmd_d.index    = cell_index_i;
    cmd_d.in_range = (32'(cell_index_i) < CellCount);
    if (action_i == ACTION_READ) begin
      cmd_d.op = OP_READ;
    end else if (char_code_i == NEWLINE_CHAR) begin
      cmd_d.op = OP_NEWLINE;
    end else begin
      cmd_d.op = OP_PUT;
    end
  end

  always_comb begin
    hold_d = hold_q;
    if (accept) begin
      hold_d = 1'b1;
    end else if (push_ready_i) begin
      hold_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
    end else begin
      hold_q <= hold_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

[rtl/core/tcw_queue.sv]
// Short command queue between the front end and the back end of the
// text console writer. Uses tcw_pkg.
`timescale 1ns / 1ps

module tcw_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  tcw_pkg::tcw_cmd_t push_cmd_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output tcw_pkg::tcw_cmd_t pop_cmd_o
);

  import tcw_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  tcw_cmd_t            entries_q [QUEUE_DEPTH];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                push, pop;

  assign push_ready_o = (count_q != CntW'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_cmd_o    = entries_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : PtrW'(wr_ptr_q + 1'b1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : PtrW'(rd_ptr_q + 1'b1);
    end
    if (push && !pop) begin
      count_d = CntW'(count_q + 1'b1);
    end else if (pop && !push) begin
      count_d = CntW'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

[rtl/core/tcw_back.sv]
// Back end of the text console writer: cursor, cell store, clearing and
// scroll sequencer, and the result register. Uses tcw_pkg and the
// assertion macro header.
`timescale 1ns / 1ps
`include "text_console_writer_top_assert.svh"

module tcw_back #(
  parameter int unsigned COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
  parameter int unsigned ROWS    = tcw_pkg::ROWS_DEFAULT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [tcw_pkg::COLOR_W-1:0]      text_color_i,
  input  logic                             cmd_valid_i,
  output logic                             cmd_ready_o,
  input  tcw_pkg::tcw_cmd_t                cmd_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [tcw_pkg::COL_PORT_W-1:0]   cursor_column_o,
  output logic [tcw_pkg::ROW_PORT_W-1:0]   cursor_row_o,
  output logic                             did_scroll_o,
  output logic [tcw_pkg::CELL_W-1:0]       cell_value_o,
  output logic                             clear_busy_o
);

  import tcw_pkg::*;

  localparam int unsigned CellCount = COLUMNS * ROWS;
  localparam int unsigned MoveCount = CellCount - COLUMNS;
  localparam int unsigned AddrW     = $clog2(CellCount);
  localparam int unsigned SeqW      = $clog2(CellCount + 1);
  localparam int unsigned ColW      = $clog2(COLUMNS + 1);
  localparam int unsigned RowW      = $clog2(ROWS);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SCROLL = 3'd2;
  localparam logic [2:0] S_POST   = 3'd3;
  localparam logic [2:0] S_RESP   = 3'd4;

  localparam logic [ColW-1:0] ColLast = ColW'(COLUMNS - 1);
  localparam logic [ColW-1:0] ColWrap = ColW'(COLUMNS);
  localparam logic [RowW-1:0] RowLast = RowW'(ROWS - 1);

  logic [CELL_W-1:0]  mem [CellCount];
  logic [CELL_W-1:0]  rd_data_q;

  logic [2:0]         state_q, state_d;
  logic [ColW-1:0]    col_q, col_d, col_n;
  logic [RowW-1:0]    line_q, line_d, line_n;
  logic [SeqW-1:0]    seq_q, seq_d;
  logic               post_q, post_d;
  logic               res_scroll_q, res_scroll_d;
  logic               res_rd_q, res_rd_d;
  logic               out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]  glyph_q;
  logic [COL_PORT_W-1:0] out_col_q;
  logic [ROW_PORT_W-1:0] out_row_q;
  logic               out_scroll_q;
  logic [CELL_W-1:0]  out_value_q;

  logic               wr_en, rd_en, wrap, at_last, pop, load_out;
  logic [AddrW-1:0]   wr_addr, rd_addr, cur_addr;
  logic [CELL_W-1:0]  wr_data;

  assign cmd_ready_o     = (state_q == S_IDLE);
  assign pop             = cmd_valid_i && cmd_ready_o;
  assign clear_busy_o    = (state_q == S_CLEAR);
  assign out_valid_o     = out_valid_q;
  assign cursor_column_o = out_col_q;
  assign cursor_row_o    = out_row_q;
  assign did_scroll_o    = out_scroll_q;
  assign cell_value_o    = out_value_q;

  assign wrap    = (col_q >= ColWrap) || (cmd_i.op == OP_NEWLINE);
  assign at_last = (col_q == ColLast) && (line_q == RowLast);
  assign col_n   = wrap ? '0 : col_q;
  assign line_n  = (wrap && (line_q < RowLast)) ? RowW'(line_q + 1'b1) : line_q;
  assign cur_addr = AddrW'(AddrW'(line_n) * AddrW'(COLUMNS) + AddrW'(col_n));
  assign load_out = (state_q == S_RESP) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d      = state_q;
    col_d        = col_q;
    line_d       = line_q;
    seq_d        = seq_q;
    post_d       = post_q;
    res_scroll_d = res_scroll_q;
    res_rd_d     = res_rd_q;
    wr_en        = 1'b0;
    wr_addr      = cur_addr;
    wr_data      = {text_color_i, cmd_i.glyph};
    rd_en        = 1'b0;
    rd_addr      = AddrW'(cmd_i.index);
    case (state_q)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = AddrW'(seq_q);
        wr_data = {RESET_COLOR, BLANK_CHAR};
        if (seq_q == SeqW'(CellCount - 1)) begin
          seq_d   = '0;
          state_d = S_IDLE;
        end else begin
          seq_d = SeqW'(seq_q + 1'b1);
        end
      end
      S_IDLE: begin
        if (pop) begin
          res_rd_d     = 1'b0;
          res_scroll_d = 1'b0;
          post_d       = 1'b0;
          seq_d        = '0;
          case (cmd_i.op)
            OP_READ: begin
              res_rd_d = cmd_i.in_range;
              rd_en    = cmd_i.in_range;
              state_d  = S_RESP;
            end
            OP_PUT, OP_NEWLINE: begin
              if (at_last) begin
                wr_en        = (cmd_i.op == OP_PUT);
                col_d        = '0;
                res_scroll_d = 1'b1;
                state_d      = S_SCROLL;
              end else if (wrap && (line_q >= RowLast)) begin
                col_d        = '0;
                post_d       = (cmd_i.op == OP_PUT);
                res_scroll_d = 1'b1;
                state_d      = S_SCROLL;
              end else begin
                line_d  = line_n;
                wr_en   = (cmd_i.op == OP_PUT);
                col_d   = (cmd_i.op == OP_PUT) ? ColW'(col_n + 1'b1) : col_n;
                state_d = S_RESP;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_SCROLL: begin
        rd_en   = (seq_q < SeqW'(MoveCount));
        rd_addr = AddrW'(seq_q + SeqW'(COLUMNS));
        wr_addr = AddrW'(seq_q - 1'b1);
        if (seq_q != '0) begin
          wr_en   = 1'b1;
          wr_data = (seq_q <= SeqW'(MoveCount)) ? rd_data_q : {text_color_i, BLANK_CHAR};
        end
        if (seq_q == SeqW'(CellCount)) begin
          state_d = post_q ? S_POST : S_RESP;
        end else begin
          seq_d = SeqW'(seq_q + 1'b1);
        end
      end
      S_POST: begin
        wr_en   = 1'b1;
        wr_addr = AddrW'(MoveCount);
        wr_data = {text_color_i, glyph_q};
        col_d   = ColW'(1);
        state_d = S_RESP;
      end
      S_RESP: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      col_q        <= '0;
      line_q       <= '0;
      seq_q        <= '0;
      post_q       <= 1'b0;
      res_scroll_q <= 1'b0;
      res_rd_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      col_q        <= col_d;
      line_q       <= line_d;
      seq_q        <= seq_d;
      post_q       <= post_d;
      res_scroll_q <= res_scroll_d;
      res_rd_q     <= res_rd_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      glyph_q <= cmd_i.glyph;
    end
    if (load_out) begin
      out_col_q    <= COL_PORT_W'(col_q);
      out_row_q    <= ROW_PORT_W'(line_q);
      out_scroll_q <= res_scroll_q;
      out_value_q  <= res_rd_q ? rd_data_q : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  `TCW_ASSERT_SAME(a_row_in_range, 1'b1, line_q <= RowLast, "cursor row out of range")
  `TCW_ASSERT_SAME(a_col_in_range, 1'b1, col_q <= ColWrap, "cursor column out of range")
  `TCW_ASSERT_SAME(a_scroll_col_zero, state_q == S_SCROLL, col_q == '0,
                   "cursor column not reset during scroll")
  `TCW_ASSERT_SAME(a_clear_no_result, state_q == S_CLEAR, !out_valid_q,
                   "result presented during clearing pass")
  `TCW_ASSERT_NEXT(a_scroll_last_row, load_out && res_scroll_q,
                   out_row_q == ROW_PORT_W'(RowLast), "scroll result not on last row")

endmodule

[rtl/core/text_console_writer_top.sv]
// Top level of the text console writer: text color register, front end,
// command queue and back end. Uses tcw_pkg, tcw_front, tcw_queue, tcw_back.
//
// After reset the block clears the cell store to blanks and accepts no
// transaction until that pass is done; color writes are taken at any time.
// In the back end a put, a newline or a read uses its one-write, one-read
// store port and then the result register. A put or newline that scrolls
// walks the whole store one cell per cycle, and a glyph that lands on the
// fresh last row is written in a further post step. The front end and a
// two-entry queue keep accepting transactions, until they are full, while
// the back end works or a result waits.
`timescale 1ns / 1ps

module text_console_writer_top #(
  parameter int unsigned COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
  parameter int unsigned ROWS    = tcw_pkg::ROWS_DEFAULT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tcw_pkg::COLOR_W-1:0]      cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [tcw_pkg::ACTION_W-1:0]     action_i,
  input  logic [tcw_pkg::CHAR_W-1:0]       char_code_i,
  input  logic [tcw_pkg::INDEX_W-1:0]      cell_index_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [tcw_pkg::COL_PORT_W-1:0]   cursor_column_o,
  output logic [tcw_pkg::ROW_PORT_W-1:0]   cursor_row_o,
  output logic                             did_scroll_o,
  output logic [tcw_pkg::CELL_W-1:0]       cell_value_o
);

  import tcw_pkg::*;

  logic [COLOR_W-1:0] text_color_q;
  logic               clear_busy;
  logic               push_valid, push_ready, pop_valid, pop_ready;
  tcw_cmd_t           push_cmd, pop_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_color_q <= RESET_COLOR;
    end else if (cfg_we_i) begin
      text_color_q <= cfg_wdata_i;
    end
  end

  tcw_front #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_busy_i (clear_busy),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .char_code_i  (char_code_i),
    .cell_index_i (cell_index_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  tcw_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  tcw_back #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .text_color_i    (text_color_q),
    .cmd_valid_i     (pop_valid),
    .cmd_ready_o     (pop_ready),
    .cmd_i           (pop_cmd),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .cursor_column_o (cursor_column_o),
    .cursor_row_o    (cursor_row_o),
    .did_scroll_o    (did_scroll_o),
    .cell_value_o    (cell_value_o),
    .clear_busy_o    (clear_busy)
  );

endmodule

[verif/testbench.sv]
// Self-checking testbench for text_console_writer_top: directed and random put,
// newline and read transactions, checked against a behavioral screen model.
// Depends on tcw_pkg and the RTL of the text console writer only.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned COLUMNS    = tcw_pkg::COLUMNS_DEFAULT;
  localparam int unsigned ROWS       = tcw_pkg::ROWS_DEFAULT;
  localparam int unsigned CELL_COUNT = COLUMNS * ROWS;
  localparam int unsigned CHAR_W     = tcw_pkg::CHAR_W;
  localparam int unsigned INDEX_W    = tcw_pkg::INDEX_W;
  localparam int unsigned COLOR_W    = tcw_pkg::COLOR_W;
  localparam int unsigned INDEX_MAX  = (1 << tcw_pkg::INDEX_W) - 1;
  localparam logic [tcw_pkg::ACTION_W-1:0] ACTION_PUT = 1'b0;

  typedef struct packed {
    logic [tcw_pkg::COL_PORT_W-1:0] column;
    logic [tcw_pkg::ROW_PORT_W-1:0] row;
    logic                           scrolled;
    logic [tcw_pkg::CELL_W-1:0]     cell_word;
  } console_status_t;

  typedef enum int {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_SPARSE,
    RDY_PERIODIC
  } ready_mode_e;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [tcw_pkg::COLOR_W-1:0]    cfg_wdata_i;
  logic                           in_valid_i;
  logic                           in_ready_o;
  logic [tcw_pkg::ACTION_W-1:0]   action_i;
  logic [tcw_pkg::CHAR_W-1:0]     char_code_i;
  logic [tcw_pkg::INDEX_W-1:0]    cell_index_i;
  logic                           out_valid_o;
  logic                           out_ready_i;
  logic [tcw_pkg::COL_PORT_W-1:0] cursor_column_o;
  logic [tcw_pkg::ROW_PORT_W-1:0] cursor_row_o;
  logic                           did_scroll_o;
  logic [tcw_pkg::CELL_W-1:0]     cell_value_o;

  // Screen model and the status words it predicts.
  logic [tcw_pkg::CELL_W-1:0]  screen_model [CELL_COUNT];
  int unsigned                 cur_col;
  int unsigned                 cur_row;
  logic [tcw_pkg::COLOR_W-1:0] color_model;
  console_status_t             expected_status_q [$];

  int errors;
  int burst_left;
  int n_puts;
  int n_newlines;
  int n_reads;
  int n_scrolls;
  int n_color_writes;

  text_console_writer_top #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .char_code_i    (char_code_i),
    .cell_index_i   (cell_index_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .cursor_column_o(cursor_column_o),
    .cursor_row_o   (cursor_row_o),
    .did_scroll_o   (did_scroll_o),
    .cell_value_o   (cell_value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #100_000_000;
    $display("Timeout with %0d results still outstanding.", expected_status_q.size());
    $display("== FAIL ==");
    $finish;
  end

  function automatic void scroll_screen_model();
    for (int i = 0; i + COLUMNS < CELL_COUNT; i++) begin
      screen_model[i] = screen_model[i + COLUMNS];
    end
    for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) begin
      screen_model[i] = {color_model, tcw_pkg::BLANK_CHAR};
    end
  endfunction

  function automatic console_status_t predict_console_step(
    logic [tcw_pkg::ACTION_W-1:0] action,
    logic [tcw_pkg::CHAR_W-1:0]   glyph,
    logic [tcw_pkg::INDEX_W-1:0]  index
  );
    console_status_t res;
    res = '0;
    if (action == tcw_pkg::ACTION_READ) begin
      if (index < CELL_COUNT) res.cell_word = screen_model[index];
    end else if (cur_col == COLUMNS - 1 && cur_row == ROWS - 1) begin
      if (glyph != tcw_pkg::NEWLINE_CHAR) begin
        screen_model[cur_row * COLUMNS + cur_col] = {color_model, glyph};
      end
      scroll_screen_model();
      res.scrolled = 1'b1;
      cur_col = 0;
    end else begin
      if (cur_col >= COLUMNS || glyph == tcw_pkg::NEWLINE_CHAR) begin
        cur_col = 0;
        if (cur_row >= ROWS - 1) begin
          scroll_screen_model();
          res.scrolled = 1'b1;
        end else begin
          cur_row++;
        end
      end
      if (glyph != tcw_pkg::NEWLINE_CHAR) begin
        screen_model[cur_row * COLUMNS + cur_col] = {color_model, glyph};
        cur_col++;
      end
    end
    res.column = cur_col[tcw_pkg::COL_PORT_W-1:0];
    res.row    = cur_row[tcw_pkg::ROW_PORT_W-1:0];
    return res;
  endfunction

  function automatic logic [tcw_pkg::CHAR_W-1:0] random_glyph();
    logic [tcw_pkg::CHAR_W-1:0] g;
    g = CHAR_W'($urandom_range(0, 255));
    if (g == tcw_pkg::NEWLINE_CHAR) g = tcw_pkg::BLANK_CHAR;
    return g;
  endfunction

  // The sender works in bursts; a random gap with valid low may come before each burst.
  task automatic send_item(
    input logic [tcw_pkg::ACTION_W-1:0] action,
    input logic [tcw_pkg::CHAR_W-1:0]   glyph,
    input logic [tcw_pkg::INDEX_W-1:0]  index
  );
    console_status_t exp_res;
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    action_i     <= action;
    char_code_i  <= glyph;
    cell_index_i <= index;
    do @(posedge clk_i); while (!in_ready_o);
    exp_res = predict_console_step(action, glyph, index);
    expected_status_q.push_back(exp_res);
    if (action == tcw_pkg::ACTION_READ) n_reads++;
    else if (glyph == tcw_pkg::NEWLINE_CHAR) n_newlines++;
    else n_puts++;
    if (exp_res.scrolled) n_scrolls++;
  endtask

  task automatic put_glyph(input logic [tcw_pkg::CHAR_W-1:0] glyph);
    send_item(ACTION_PUT, glyph, INDEX_W'($urandom_range(0, INDEX_MAX)));
  endtask

  task automatic read_cell(input int unsigned index);
    send_item(tcw_pkg::ACTION_READ, CHAR_W'($urandom_range(0, 255)), INDEX_W'(index));
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (expected_status_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_color(input logic [tcw_pkg::COLOR_W-1:0] value);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    color_model = value;
    n_color_writes++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_reset_screen();
    read_cell(0);
    read_cell(CELL_COUNT - 1);
    read_cell(CELL_COUNT);
    read_cell(INDEX_MAX);
    read_cell(CELL_COUNT / 2);
  endtask

  task automatic test_glyph_extremes();
    put_glyph(8'h00);
    put_glyph(8'hFF);
    put_glyph(tcw_pkg::BLANK_CHAR);
    put_glyph(tcw_pkg::NEWLINE_CHAR);
    put_glyph(8'h7F);
    read_cell(0);
    read_cell(1);
    read_cell(2);
    read_cell(COLUMNS);
  endtask

  task automatic test_color_register();
    write_color(8'h00);
    put_glyph(8'h41);
    write_color(8'hFF);
    put_glyph(8'h42);
    read_cell(COLUMNS + 1);
    read_cell(COLUMNS + 2);
  endtask

  // Fill the current line until a wrap is pending, then let the next glyph wrap.
  task automatic test_line_wrap();
    write_color(COLOR_W'($urandom_range(0, 255)));
    while (cur_col < COLUMNS) put_glyph(random_glyph());
    put_glyph(random_glyph());
    read_cell(cur_row * COLUMNS);
    read_cell(cur_row * COLUMNS - 1);
  endtask

  // Walk down to the last row; a newline there scrolls instead of moving down.
  task automatic test_bottom_scroll();
    while (cur_row < ROWS - 1) put_glyph(tcw_pkg::NEWLINE_CHAR);
    repeat (5) put_glyph(random_glyph());
    put_glyph(tcw_pkg::NEWLINE_CHAR);
    read_cell((ROWS - 2) * COLUMNS);
    read_cell((ROWS - 1) * COLUMNS);
    read_cell(CELL_COUNT - 1);
  endtask

  // A glyph at the last cell is written and scrolled up at once; a newline
  // there only scrolls.
  task automatic test_last_cell();
    write_color(8'h1E);
    while (cur_col < COLUMNS - 1) put_glyph(random_glyph());
    put_glyph(8'h5A);
    read_cell(CELL_COUNT - COLUMNS - 1);
    read_cell(CELL_COUNT - 1);
    while (cur_col < COLUMNS - 1) put_glyph(random_glyph());
    put_glyph(tcw_pkg::NEWLINE_CHAR);
    read_cell(CELL_COUNT - COLUMNS - 1);
    read_cell(CELL_COUNT - 1);
    put_glyph(random_glyph());
  endtask

  task automatic test_random_traffic(input int count);
    int sent;
    int pick;
    for (int phase = 0; phase < 4; phase++) begin
      write_color(phase == 3 ? tcw_pkg::RESET_COLOR : 8'($urandom_range(0, 255)));
      sent = 0;
      while (sent < count / 4) begin
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
          repeat ($urandom_range(20, COLUMNS - 1)) begin
            put_glyph(random_glyph());
            sent++;
          end
        end else begin
          if (pick < 13) read_cell($urandom_range(0, CELL_COUNT - 1));
          else if (pick < 22) read_cell(cur_row * COLUMNS + $urandom_range(0, COLUMNS - 1));
          else if (pick < 26) read_cell($urandom_range(CELL_COUNT, INDEX_MAX));
          else if (pick < 38) put_glyph(tcw_pkg::NEWLINE_CHAR);
          else put_glyph(CHAR_W'($urandom_range(0, 255)));
          sent++;
        end
      end
    end
  endtask

  // The receiver stalls on a pattern that changes from segment to segment.
  initial begin : result_stall
    ready_mode_e mode;
    int seg;
    int tick;
    out_ready_i = 1'b0;
    tick = 0;
    forever begin
      mode = ready_mode_e'($urandom_range(0, 3));
      seg  = $urandom_range(16, 160);
      repeat (seg) begin
        @(negedge clk_i);
        tick++;
        case (mode)
          RDY_ALWAYS: begin
            out_ready_i <= 1'b1;
          end
          RDY_COIN: begin
            out_ready_i <= 1'($urandom_range(0, 1));
          end
          RDY_SPARSE: begin
            out_ready_i <= ($urandom_range(0, 3) == 0);
          end
          default: begin
            out_ready_i <= (tick % 3 != 0);
          end
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    console_status_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_status_q.size() == 0) begin
        $display("[%0t] Unexpected result: column %0d row %0d scroll %0b cell %h", $time,
                 cursor_column_o, cursor_row_o, did_scroll_o, cell_value_o);
        errors++;
      end else begin
        exp_res = expected_status_q.pop_front();
        if ({cursor_column_o, cursor_row_o, did_scroll_o, cell_value_o} !== exp_res) begin
          $display("[%0t] Mismatch: expected column %0d row %0d scroll %0b cell %h", $time,
                   exp_res.column, exp_res.row, exp_res.scrolled, exp_res.cell_word);
          $display("[%0t]           actual column %0d row %0d scroll %0b cell %h", $time,
                   cursor_column_o, cursor_row_o, did_scroll_o, cell_value_o);
          errors++;
        end
      end
    end
  end

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    action_i     = ACTION_PUT;
    char_code_i  = '0;
    cell_index_i = '0;
    errors       = 0;
    burst_left   = 0;
    n_puts = 0;
    n_newlines = 0;
    n_reads = 0;
    n_scrolls = 0;
    n_color_writes = 0;
    cur_col = 0;
    cur_row = 0;
    color_model = tcw_pkg::RESET_COLOR;
    for (int i = 0; i < CELL_COUNT; i++) begin
      screen_model[i] = {tcw_pkg::RESET_COLOR, tcw_pkg::BLANK_CHAR};
    end
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_screen();
    test_glyph_extremes();
    test_color_register();
    test_line_wrap();
    test_bottom_scroll();
    test_last_cell();
    test_random_traffic(300);

    wait_idle();
    repeat (CELL_COUNT + 16) @(posedge clk_i);
    if (expected_status_q.size() != 0) begin
      $display("[%0t] %0d results never arrived", $time, expected_status_q.size());
      errors++;
    end
    $display("Covered %0d glyph puts, %0d newlines and %0d cell reads; %0d scrolled.",
             n_puts, n_newlines, n_reads, n_scrolls);
    $display("Text color was set %0d times, including 0x00, 0xFF and the reset value.",
             n_color_writes);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
